/* rtl/core/wsp_pkg.sv */
package wsp_pkg;

   localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
   localparam logic [31:0] TAG_DATA = 32'h6174_6164;
   localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
   localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
   localparam logic [31:0] MIN_LEN  = 32'd44;
   localparam logic [31:0] FMT_MIN  = 32'd16;

   localparam logic [2:0] ST_START     = 3'd0;
   localparam logic [2:0] ST_FRAME     = 3'd1;
   localparam logic [2:0] ST_TOO_SHORT = 3'd2;
   localparam logic [2:0] ST_BAD_RIFF  = 3'd3;
   localparam logic [2:0] ST_BAD_WAVE  = 3'd4;
   localparam logic [2:0] ST_NOT_PCM   = 3'd5;
   localparam logic [2:0] ST_NOT_16BIT = 3'd6;
   localparam logic [2:0] ST_NO_DATA   = 3'd7;

   localparam int RSP_DATA_W = 72;

   typedef struct packed {
      logic       first_byte;
      logic [7:0] data_byte;
   } wsp_item_type;

   typedef struct packed {
      logic               final_res;
      logic [31:0]        rate_hz;
      logic signed [15:0] right_sample;
      logic signed [15:0] left_sample;
      logic [2:0]         status;
   } wsp_result_type;

endpackage

/* rtl/core/wsp_in_reg.sv */
module wsp_in_reg import wsp_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   output logic         in_ready,
   input  wsp_item_type in_item,
   input  logic         advance,
   output logic         item_valid,
   output wsp_item_type item
);

   logic         valid_ff, valid_in;
   wsp_item_type item_ff, item_in;

   assign in_ready   = !valid_ff || advance;
   assign item_valid = valid_ff;
   assign item       = item_ff;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (in_ready) begin
         valid_in = in_valid;
         item_in  = in_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

endmodule

/* rtl/core/wsp_parse.sv */
module wsp_parse import wsp_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic [31:0]    file_length,
   input  logic           fire,
   input  wsp_item_type   item,
   output logic           res_valid,
   output wsp_result_type res
);

   typedef enum logic [2:0] {
      PH_IDLE, PH_HEAD, PH_CHDR, PH_BODY, PH_DATA, PH_DONE
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [31:0] pos_ff, pos_in;
   logic [31:0] tag_ff, tag_in;
   logic [31:0] size_ff, size_in;
   logic [31:0] left_ff, left_in;
   logic [15:0] fmt_ff, fmt_in;
   logic [15:0] chan_ff, chan_in;
   logic [31:0] rate_ff, rate_in;
   logic [15:0] bits_ff, bits_in;
   logic [30:0] frames_ff, frames_in;
   logic [23:0] part_ff, part_in;

   logic [7:0]  b;
   logic [31:0] idx;
   logic [34:0] len35, p35, start35;
   logic [32:0] pad33, off33;
   logic [2:0]  k3;
   logic [1:0]  k2, last_k;
   logic        vd, vd_data;

   always_comb begin
      phase_in  = phase_ff;
      pos_in    = pos_ff;
      tag_in    = tag_ff;
      size_in   = size_ff;
      left_in   = left_ff;
      fmt_in    = fmt_ff;
      chan_in   = chan_ff;
      rate_in   = rate_ff;
      bits_in   = bits_ff;
      frames_in = frames_ff;
      part_in   = part_ff;
      res_valid = 1'b0;
      res       = '0;
      b         = item.data_byte;
      idx       = '0;
      len35     = {3'b000, file_length};
      p35       = '0;
      start35   = '0;
      pad33     = '0;
      off33     = '0;
      k3        = '0;
      k2        = '0;
      last_k    = '0;
      vd        = 1'b0;
      vd_data   = 1'b0;

      if (fire && item.first_byte) begin
         phase_in  = PH_HEAD;
         pos_in    = '0;
         tag_in    = '0;
         size_in   = '0;
         left_in   = '0;
         fmt_in    = '0;
         chan_in   = '0;
         rate_in   = '0;
         bits_in   = '0;
         frames_in = '0;
         part_in   = '0;
         if (file_length < MIN_LEN) begin
            pos_in          = 32'd1;
            phase_in        = PH_DONE;
            res_valid       = 1'b1;
            res.status      = ST_TOO_SHORT;
            res.final_res   = 1'b1;
         end
      end

      if (fire && !res_valid && phase_in != PH_IDLE && phase_in != PH_DONE) begin
         idx    = pos_in;
         pos_in = idx + 32'd1;
         case (phase_in)
            PH_HEAD: begin
               k2 = idx[1:0];
               if (k2 == 2'd0) tag_in = '0;
               tag_in[{k2, 3'b000} +: 8] = tag_in[{k2, 3'b000} +: 8] | b;
               if (idx == 32'd3 && tag_in != TAG_RIFF) begin
                  res_valid     = 1'b1;
                  res.status    = ST_BAD_RIFF;
                  res.final_res = 1'b1;
                  phase_in      = PH_DONE;
               end else if (idx == 32'd11) begin
                  if (tag_in != TAG_WAVE) begin
                     res_valid     = 1'b1;
                     res.status    = ST_BAD_WAVE;
                     res.final_res = 1'b1;
                     phase_in      = PH_DONE;
                  end else begin
                     phase_in = PH_CHDR;
                     left_in  = '0;
                  end
               end
            end
            PH_CHDR: begin
               k3 = left_in[2:0];
               if (!k3[2]) begin
                  if (k3 == 3'd0) tag_in = '0;
                  tag_in[{k3[1:0], 3'b000} +: 8] = tag_in[{k3[1:0], 3'b000} +: 8] | b;
               end else begin
                  if (k3 == 3'd4) size_in = '0;
                  size_in[{k3[1:0], 3'b000} +: 8] = size_in[{k3[1:0], 3'b000} +: 8] | b;
               end
               left_in = {29'd0, k3} + 32'd1;
               if (k3 == 3'd7) begin
                  p35   = {3'b000, idx} + 35'd1;
                  pad33 = ({1'b0, size_in} + 33'd1) & ~33'd1;
                  if (p35 + {3'b000, size_in} > len35) begin
                     vd = 1'b1;
                  end else if (tag_in == TAG_DATA) begin
                     vd      = 1'b1;
                     vd_data = 1'b1;
                  end else if (tag_in == TAG_FMT && size_in >= FMT_MIN) begin
                     phase_in = PH_BODY;
                     left_in  = pad33[31:0];
                  end else if (p35 + {2'b00, pad33} + 35'd8 > len35) begin
                     vd = 1'b1;
                  end else if (pad33 == '0) begin
                     left_in = '0;
                  end else begin
                     phase_in = PH_BODY;
                     left_in  = pad33[31:0];
                  end
               end
            end
            PH_BODY: begin
               pad33 = ({1'b0, size_in} + 33'd1) & ~33'd1;
               if (tag_in == TAG_FMT && size_in >= FMT_MIN) begin
                  off33 = pad33 - {1'b0, left_in};
                  case (off33)
                     33'd0: fmt_in = {8'd0, b};
                     33'd1: fmt_in[15:8] = fmt_in[15:8] | b;
                     33'd2: chan_in = {8'd0, b};
                     33'd3: chan_in[15:8] = chan_in[15:8] | b;
                     33'd4: rate_in = {24'd0, b};
                     33'd5: rate_in[15:8] = rate_in[15:8] | b;
                     33'd6: rate_in[23:16] = rate_in[23:16] | b;
                     33'd7: rate_in[31:24] = rate_in[31:24] | b;
                     33'd14: bits_in = {8'd0, b};
                     33'd15: begin
                        bits_in[15:8] = bits_in[15:8] | b;
                        start35 = {3'b000, idx} - 35'd15;
                        if (start35 + {2'b00, pad33} + 35'd8 > len35) vd = 1'b1;
                     end
                     default: ;
                  endcase
               end
               if (!vd) begin
                  if (left_in != '0) left_in = left_in - 32'd1;
                  if (left_in == '0) phase_in = PH_CHDR;
               end
            end
            PH_DATA: begin
               k2     = left_in[1:0];
               last_k = (chan_in == 16'd1) ? 2'd1 : 2'd3;
               if (k2 < last_k) begin
                  part_in[{k2, 3'b000} +: 8] = part_in[{k2, 3'b000} +: 8] | b;
                  left_in = {30'd0, k2} + 32'd1;
               end else begin
                  if (last_k == 2'd1) begin
                     res.left_sample  = {b, part_in[7:0]};
                     res.right_sample = {b, part_in[7:0]};
                  end else begin
                     res.left_sample  = part_in[15:0];
                     res.right_sample = {b, part_in[23:16]};
                  end
                  part_in = '0;
                  left_in = '0;
                  if (frames_in != '0) frames_in = frames_in - 31'd1;
                  res_valid     = 1'b1;
                  res.status    = ST_FRAME;
                  res.final_res = (frames_in == '0);
                  if (frames_in == '0) phase_in = PH_DONE;
               end
            end
            default: ;
         endcase

         if (vd) begin
            res_valid     = 1'b1;
            res.final_res = 1'b1;
            phase_in      = PH_DONE;
            if (fmt_in != 16'd1) begin
               res.status = ST_NOT_PCM;
            end else if (bits_in != 16'd16) begin
               res.status = ST_NOT_16BIT;
            end else if (!vd_data || size_in == '0) begin
               res.status = ST_NO_DATA;
            end else begin
               frames_in     = (chan_in == 16'd1) ? size_in[31:1] : {1'b0, size_in[31:2]};
               left_in       = '0;
               part_in       = '0;
               res.status    = ST_START;
               res.rate_hz   = rate_in;
               res.final_res = (frames_in == '0);
               phase_in      = (frames_in == '0) ? PH_DONE : PH_DATA;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_IDLE;
         pos_ff    <= '0;
         tag_ff    <= '0;
         size_ff   <= '0;
         left_ff   <= '0;
         fmt_ff    <= '0;
         chan_ff   <= '0;
         rate_ff   <= '0;
         bits_ff   <= '0;
         frames_ff <= '0;
         part_ff   <= '0;
      end else begin
         phase_ff  <= phase_in;
         pos_ff    <= pos_in;
         tag_ff    <= tag_in;
         size_ff   <= size_in;
         left_ff   <= left_in;
         fmt_ff    <= fmt_in;
         chan_ff   <= chan_in;
         rate_ff   <= rate_in;
         bits_ff   <= bits_in;
         frames_ff <= frames_in;
         part_ff   <= part_in;
      end
   end

endmodule

/* rtl/core/wsp_out_reg.sv */
module wsp_out_reg import wsp_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           res_valid,
   input  wsp_result_type res,
   output logic           advance,
   output logic           out_valid,
   input  logic           out_ready,
   output wsp_result_type out_res
);

   logic           valid_ff, valid_in;
   wsp_result_type res_ff, res_in;

   assign advance   = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_res   = res_ff;

   always_comb begin
      valid_in = valid_ff && !out_ready;
      res_in   = res_ff;
      if (advance) begin
         valid_in = res_valid;
         res_in   = res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      res_ff <= res_in;
   end

endmodule

/* rtl/core/wav_stream_parser_core.sv */
// Byte-serial RIFF/WAVE parser for 16-bit PCM files.
// Input channel req_*: one file byte per item in req_tdata; req_tuser marks
// byte zero of a new file and restarts the parse. Set the file length on
// csr_wdata with csr_we before the first byte of a file.
// Result channel rsp_*: status, left/right samples and sample rate packed in
// rsp_tdata; rsp_tlast marks the last frame, any error, or a start item
// with no frames. At most one result item per input byte.
// Path: a byte is held in the input register, then its result in the result
// register, which drives rsp.
// Throughput: one byte per cycle while the result register can advance, as
// the header and frame logic between the two registers is combinational.
// Back-pressure: when rsp_tready is low the result register holds; one more
// byte sits in the input register, then req_tready drops.
// Reset: both registers empty, file length zero, parser idle until a byte
// marked by req_tuser arrives; unmarked bytes before it are dropped.
module wav_stream_parser_core import wsp_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [31:0]           csr_wdata,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [7:0]            req_tdata,   // data_byte
   input  logic                  req_tuser,   // first_byte
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // status, left, right, rate_hz, zero fill
   output logic                  rsp_tlast    // final_res
);

   logic [31:0]    file_length_ff, file_length_in;
   logic           advance;
   logic           item_valid;
   wsp_item_type   in_item, item;
   logic           res_valid;
   wsp_result_type res, out_res;

   assign file_length_in = csr_we ? csr_wdata : file_length_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         file_length_ff <= '0;
      end else begin
         file_length_ff <= file_length_in;
      end
   end

   assign in_item.data_byte  = req_tdata;
   assign in_item.first_byte = req_tuser;

   wsp_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_item    (in_item),
      .advance    (advance),
      .item_valid (item_valid),
      .item       (item)
   );

   wsp_parse u_parse (
      .clock       (clock),
      .reset       (reset),
      .file_length (file_length_ff),
      .fire        (item_valid && advance),
      .item        (item),
      .res_valid   (res_valid),
      .res         (res)
   );

   wsp_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .res_valid (res_valid),
      .res       (res),
      .advance   (advance),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_res   (out_res)
   );

   assign rsp_tdata = {5'd0, out_res.rate_hz, out_res.right_sample,
                       out_res.left_sample, out_res.status};
   assign rsp_tlast = out_res.final_res;

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
   import wsp_pkg::*;

   typedef enum logic [2:0] {
      PH_IDLE, PH_HEAD, PH_CHDR, PH_BODY, PH_DATA, PH_DONE
   } parse_phase_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_we = 1'b0;
   logic [31:0]           csr_wdata = '0;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [7:0]            req_tdata = '0;
   logic                  req_tuser = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tlast;

   wav_stream_parser_core dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always #5 clock = ~clock;

   wsp_item_type   bytes_to_send[$];
   wsp_result_type results_due[$];
   logic [7:0]     file_bytes[$];

   int unsigned req_gap_max = 0;
   int unsigned rsp_stall_max = 0;
   int unsigned req_gap = 0;
   int unsigned rsp_stall = 0;
   int unsigned error_count = 0;
   int unsigned result_count = 0;

   // parser state as seen by the checker
   logic [31:0]     file_len = '0;
   parse_phase_type phase = PH_IDLE;
   logic [31:0]     byte_pos, hdr_tag, hdr_size, walk_count;
   logic [15:0]     fmt_code, chan_count, bit_depth;
   logic [31:0]     fmt_rate;
   logic [30:0]     frames_left;
   logic [23:0]     frame_bytes;

   function automatic void clear_parse();
      phase       = PH_IDLE;
      byte_pos    = '0;
      hdr_tag     = '0;
      hdr_size    = '0;
      walk_count  = '0;
      fmt_code    = '0;
      chan_count  = '0;
      fmt_rate    = '0;
      bit_depth   = '0;
      frames_left = '0;
      frame_bytes = '0;
   endfunction

   function automatic logic [63:0] padded_len(logic [31:0] s);
      return (64'(s) + 64'd1) & ~64'd1;
   endfunction

   function automatic wsp_result_type make_result(logic [2:0] st, logic [15:0] l,
                                                  logic [15:0] r, logic [31:0] rate,
                                                  logic fin);
      wsp_result_type res;
      res.status       = st;
      res.left_sample  = l;
      res.right_sample = r;
      res.rate_hz      = rate;
      res.final_res    = fin;
      if (fin) phase = PH_DONE;
      return res;
   endfunction

   function automatic wsp_result_type wav_verdict(bit have_data);
      if (fmt_code != 16'd1) return make_result(ST_NOT_PCM, '0, '0, '0, 1'b1);
      if (bit_depth != 16'd16) return make_result(ST_NOT_16BIT, '0, '0, '0, 1'b1);
      if (!have_data || hdr_size == '0) return make_result(ST_NO_DATA, '0, '0, '0, 1'b1);
      frames_left = (chan_count == 16'd1) ? 31'(hdr_size >> 1) : 31'(hdr_size >> 2);
      walk_count  = '0;
      frame_bytes = '0;
      phase       = PH_DATA;
      return make_result(ST_START, '0, '0, fmt_rate, frames_left == '0);
   endfunction

   task automatic parse_wav_byte(input wsp_item_type it, output bit got,
                                 output wsp_result_type res);
      logic [31:0] b32, idx;
      logic [63:0] len, p, off;
      logic [15:0] l, r;
      int unsigned k, last;
      b32 = {24'd0, it.data_byte};
      got = 1'b0;
      res = '0;
      if (it.first_byte) begin
         clear_parse();
         phase = PH_HEAD;
         if (file_len < MIN_LEN) begin
            byte_pos = 32'd1;
            got = 1'b1;
            res = make_result(ST_TOO_SHORT, '0, '0, '0, 1'b1);
            return;
         end
      end
      if (phase == PH_IDLE || phase == PH_DONE) return;
      len = 64'(file_len);
      idx = byte_pos;
      byte_pos = idx + 32'd1;
      case (phase)
         PH_HEAD: begin
            k = idx[1:0];
            if (k == 0) hdr_tag = '0;
            hdr_tag |= b32 << (8 * k);
            if (idx == 32'd3 && hdr_tag != TAG_RIFF) begin
               got = 1'b1;
               res = make_result(ST_BAD_RIFF, '0, '0, '0, 1'b1);
            end else if (idx == 32'd11) begin
               if (hdr_tag != TAG_WAVE) begin
                  got = 1'b1;
                  res = make_result(ST_BAD_WAVE, '0, '0, '0, 1'b1);
               end else begin
                  phase = PH_CHDR;
                  walk_count = '0;
               end
            end
         end
         PH_CHDR: begin
            k = walk_count[2:0];
            if (k < 4) begin
               if (k == 0) hdr_tag = '0;
               hdr_tag |= b32 << (8 * k);
            end else begin
               if (k == 4) hdr_size = '0;
               hdr_size |= b32 << (8 * (k - 4));
            end
            walk_count = k + 1;
            if (k == 7) begin
               p = 64'(idx) + 64'd1;
               if (p + 64'(hdr_size) > len) begin
                  got = 1'b1;
                  res = wav_verdict(1'b0);
               end else if (hdr_tag == TAG_DATA) begin
                  got = 1'b1;
                  res = wav_verdict(1'b1);
               end else if (hdr_tag == TAG_FMT && hdr_size >= FMT_MIN) begin
                  phase = PH_BODY;
                  walk_count = 32'(padded_len(hdr_size));
               end else if (p + padded_len(hdr_size) + 64'd8 > len) begin
                  got = 1'b1;
                  res = wav_verdict(1'b0);
               end else if (padded_len(hdr_size) == '0) begin
                  walk_count = '0;
               end else begin
                  phase = PH_BODY;
                  walk_count = 32'(padded_len(hdr_size));
               end
            end
         end
         PH_BODY: begin
            if (hdr_tag == TAG_FMT && hdr_size >= FMT_MIN) begin
               off = padded_len(hdr_size) - 64'(walk_count);
               if (off == 0) fmt_code = {8'd0, it.data_byte};
               else if (off == 1) fmt_code |= {it.data_byte, 8'd0};
               else if (off == 2) chan_count = {8'd0, it.data_byte};
               else if (off == 3) chan_count |= {it.data_byte, 8'd0};
               else if (off >= 4 && off <= 7) begin
                  if (off == 4) fmt_rate = '0;
                  fmt_rate |= b32 << (8 * (off - 4));
               end else if (off == 14) bit_depth = {8'd0, it.data_byte};
               else if (off == 15) begin
                  bit_depth |= {it.data_byte, 8'd0};
                  if (64'(idx) - 64'd15 + padded_len(hdr_size) + 64'd8 > len) begin
                     got = 1'b1;
                     res = wav_verdict(1'b0);
                  end
               end
            end
            if (!got) begin
               if (walk_count > 0) walk_count--;
               if (walk_count == 0) phase = PH_CHDR;
            end
         end
         PH_DATA: begin
            k = walk_count[1:0];
            last = (chan_count == 16'd1) ? 1 : 3;
            if (k < last) begin
               frame_bytes = 24'(32'(frame_bytes) | (b32 << (8 * k)));
               walk_count = k + 1;
            end else begin
               if (last == 1) begin
                  l = {it.data_byte, frame_bytes[7:0]};
                  r = l;
               end else begin
                  l = frame_bytes[15:0];
                  r = {it.data_byte, frame_bytes[23:16]};
               end
               frame_bytes = '0;
               walk_count = '0;
               if (frames_left > 0) frames_left--;
               got = 1'b1;
               res = make_result(ST_FRAME, l, r, '0, frames_left == '0);
            end
         end
         default: ;
      endcase
   endtask

   task automatic flag_error(input string msg);
      $display("ERROR @%0t: %s", $time, msg);
      error_count++;
   endtask

   task automatic check_field(input string name, input logic [31:0] seen_v,
                              input logic [31:0] want_v);
      if (seen_v !== want_v)
         flag_error($sformatf("result %0d %s: got %0h, expected %0h",
                              result_count, name, seen_v, want_v));
   endtask

   always @(posedge clock) begin
      wsp_result_type res;
      wsp_item_type   nxt;
      bit             got;
      if (reset) begin
         req_tvalid <= 1'b0;
         req_gap = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            parse_wav_byte({req_tuser, req_tdata}, got, res);
            if (got) results_due.push_back(res);
         end
         if (!req_tvalid || req_tready) begin
            if (req_gap > 0) begin
               req_gap--;
               req_tvalid <= 1'b0;
            end else if (bytes_to_send.size() != 0) begin
               nxt = bytes_to_send.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= nxt.data_byte;
               req_tuser  <= nxt.first_byte;
               req_gap = $urandom_range(0, req_gap_max);
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      wsp_result_type seen, want;
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_stall = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            seen = wsp_result_type'({rsp_tlast, rsp_tdata[66:0]});
            if (results_due.size() == 0) begin
               flag_error($sformatf("unexpected result, status %0d", seen.status));
            end else begin
               want = results_due.pop_front();
               check_field("status", 32'(seen.status), 32'(want.status));
               check_field("left", 32'(unsigned'(seen.left_sample)),
                           32'(unsigned'(want.left_sample)));
               check_field("right", 32'(unsigned'(seen.right_sample)),
                           32'(unsigned'(want.right_sample)));
               check_field("rate", seen.rate_hz, want.rate_hz);
               check_field("last", 32'(seen.final_res), 32'(want.final_res));
            end
            result_count++;
            rsp_stall = $urandom_range(0, rsp_stall_max);
         end
         if (rsp_stall > 0) begin
            rsp_stall--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   task automatic wait_idle();
      do @(negedge clock);
      while (bytes_to_send.size() != 0 || req_tvalid || results_due.size() != 0);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_length(input logic [31:0] v);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      csr_we    <= 1'b0;
      file_len = v;
   endtask

   task automatic pick_pacing();
      case ($urandom_range(0, 2))
         0: req_gap_max = 0;
         1: req_gap_max = 3;
         default: req_gap_max = 15;
      endcase
      case ($urandom_range(0, 2))
         0: rsp_stall_max = 0;
         1: rsp_stall_max = 3;
         default: rsp_stall_max = 15;
      endcase
   endtask

   task automatic push_byte(input logic [7:0] b, input logic mark);
      wsp_item_type it;
      it.first_byte = mark;
      it.data_byte  = b;
      bytes_to_send.push_back(it);
   endtask

   task automatic put32(input logic [31:0] v);
      for (int i = 0; i < 4; i++) file_bytes.push_back(v[8*i +: 8]);
   endtask

   task automatic put16(input logic [15:0] v);
      file_bytes.push_back(v[7:0]);
      file_bytes.push_back(v[15:8]);
   endtask

   task automatic put_random(input int unsigned n);
      repeat (n) file_bytes.push_back(8'($urandom));
   endtask

   task automatic put_junk_chunk();
      logic [31:0] sz;
      sz = ($urandom_range(0, 19) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 1)
                                        : $urandom_range(0, 7);
      put32($urandom);
      put32(sz);
      put_random(sz > 32'd8 ? 8 : 32'(padded_len(sz)));
   endtask

   task automatic build_wav();
      logic [31:0] fsize, dsize, rate;
      logic [15:0] code, chans, depth;
      int unsigned pick;
      file_bytes.delete();
      put32(TAG_RIFF);
      put32($urandom);
      put32(TAG_WAVE);
      if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 2)) put_junk_chunk();
      if ($urandom_range(0, 9) != 0) begin
         pick = $urandom_range(0, 9);
         fsize = (pick < 6) ? 32'd16 : (pick < 8) ? 32'd18 : (pick == 8) ? 32'd17 : 32'd14;
         put32(TAG_FMT);
         put32(fsize);
         if (fsize < FMT_MIN) begin
            put_random(fsize);
         end else begin
            code = ($urandom_range(0, 9) != 0) ? 16'd1 : 16'($urandom);
            pick = $urandom_range(0, 9);
            if (pick < 4) chans = 16'd1;
            else if (pick < 8) chans = 16'd2;
            else if (pick == 8) chans = ($urandom_range(0, 1) == 0) ? 16'd0 : 16'hFFFF;
            else chans = 16'($urandom);
            pick = $urandom_range(0, 19);
            rate = (pick == 0) ? 32'd0 : (pick == 1) ? 32'hFFFF_FFFF : $urandom;
            pick = $urandom_range(0, 9);
            depth = (pick != 0) ? 16'd16 : 16'($urandom);
            put16(code);
            put16(chans);
            put32(rate);
            put32($urandom);
            put16(16'($urandom));
            put16(depth);
            put_random(32'(padded_len(fsize)) - 16);
         end
      end
      if ($urandom_range(0, 4) == 0) put_junk_chunk();
      if ($urandom_range(0, 9) != 0) begin
         dsize = ($urandom_range(0, 7) == 0) ? 32'd0 : $urandom_range(1, 24);
         put32(TAG_DATA);
         put32(dsize);
         put_random(dsize);
      end
      if ($urandom_range(0, 4) == 0) put_random($urandom_range(1, 6));
   endtask

   task automatic send_file(input int unsigned split_at, input logic [31:0] second_len);
      for (int unsigned i = 0; i < file_bytes.size(); i++) begin
         if (split_at != 0 && i == split_at) begin
            wait_idle();
            write_length(second_len);
         end
         push_byte(file_bytes[i], i == 0);
      end
   endtask

   initial begin
      int unsigned file_items, n, pick, idx, split_at;
      logic [31:0] flen, len2;
      clear_parse();
      file_items = 0;
      req_gap_max = 15;
      rsp_stall_max = 15;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed: strays before any file, too-short extremes, broken tags
      push_byte(8'h00, 1'b0);
      push_byte(8'hFF, 1'b0);
      wait_idle();
      write_length(32'd0);
      push_byte(8'hFF, 1'b1);
      push_byte(8'h52, 1'b0);
      wait_idle();
      write_length(32'd43);
      push_byte(8'h52, 1'b1);
      wait_idle();
      write_length(32'hFFFF_FFFF);
      file_bytes.delete();
      put32(TAG_RIFF ^ 32'h0100_0000);
      send_file(0, '0);
      wait_idle();
      write_length(32'd44);
      file_bytes.delete();
      put32(TAG_RIFF);
      put32(32'hFFFF_FFFF);
      put32(TAG_WAVE ^ 32'h0000_0080);
      send_file(0, '0);
      wait_idle();

      while (file_items < 1100) begin
         pick_pacing();
         pick = $urandom_range(0, 99);
         if (pick < 60) begin
            build_wav();
            n = file_bytes.size();
            pick = $urandom_range(0, 99);
            if (pick < 65) flen = n;
            else if (pick < 77) flen = n + $urandom_range(1, 40);
            else if (pick < 89) flen = $urandom_range(44, n);
            else if (pick < 94) flen = 32'hFFFF_FFFF;
            else flen = $urandom_range(0, n);
            split_at = 0;
            len2 = flen;
            if ($urandom_range(0, 9) == 0) begin
               split_at = $urandom_range(1, n - 1);
               len2 = ($urandom_range(0, 1) == 0) ? 32'(n) : 32'($urandom_range(0, n + 8));
            end
            write_length(flen);
            send_file(split_at, len2);
            file_items += n;
         end else if (pick < 72) begin
            build_wav();
            idx = $urandom_range(0, 7);
            if (idx >= 4) idx += 4;
            file_bytes[idx] = file_bytes[idx] ^ 8'($urandom_range(1, 255));
            write_length(file_bytes.size());
            send_file(0, '0);
            file_items += file_bytes.size();
         end else if (pick < 80) begin
            write_length($urandom_range(0, 43));
            push_byte(8'($urandom), 1'b1);
            file_items++;
         end else if (pick < 88) begin
            write_length($urandom_range(0, 1) == 0 ? 32'($urandom_range(0, 80)) : $urandom);
            repeat ($urandom_range(8, 30))
               push_byte(8'($urandom), $urandom_range(0, 7) == 0);
         end else begin
            build_wav();
            write_length(file_bytes.size());
            n = $urandom_range(1, file_bytes.size() - 1);
            for (int unsigned i = 0; i < n; i++) push_byte(file_bytes[i], i == 0);
            file_items += n;
         end
         if ($urandom_range(0, 4) == 0)
            repeat ($urandom_range(1, 3)) push_byte(8'($urandom), 1'b0);
         wait_idle();
      end

      wait_idle();
      if (error_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("== FAIL ==");
      $finish;
   end

endmodule
